### hdl/owvcs_pkg.sv
// Shared types and constants for the one-wire voice command sender.
`timescale 1ns / 1ps
`default_nettype none
package owvcs_pkg;

   localparam int START_W = 16;
   localparam int FINE_W  = 8;
   localparam int BYTE_W  = 8;
   localparam int BIT_W   = 4;
   localparam int OP_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [BIT_W-1:0]   BYTE_BITS  = 4'd8;
   localparam logic [START_W-1:0] START_MAX  = 16'hFFFF;
   localparam logic [FINE_W-1:0]  FINE_MAX   = 8'hFF;

   // request codes
   localparam logic [OP_W-1:0] OP_NONE = 2'd0;
   localparam logic [OP_W-1:0] OP_CMD  = 2'd1;
   localparam logic [OP_W-1:0] OP_PLAY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_LOW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_END   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_OP   = 3'd4;

   // register reset values
   localparam logic [START_W-1:0] START_LOW_RST = 16'd500;
   localparam logic [FINE_W-1:0]  ONE_HIGH_RST  = 8'd6;
   localparam logic [FINE_W-1:0]  ZERO_HIGH_RST = 8'd2;
   localparam logic [FINE_W-1:0]  BIT_END_RST   = 8'd8;
   localparam logic [BYTE_W-1:0]  PLAY_OP_RST   = 8'hF3;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_START = 4'b0010,
      PH_CMD   = 4'b0100,
      PH_ADDR  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [START_W-1:0] start_low_ticks;
      logic [FINE_W-1:0]  one_high_ticks;
      logic [FINE_W-1:0]  zero_high_ticks;
      logic [FINE_W-1:0]  bit_end_ticks;
      logic [BYTE_W-1:0]  play_opcode;
   } cfg_type;

   typedef struct packed {
      logic line_level;
      logic busy;
   } rslt_type;

endpackage
`default_nettype wire

### hdl/one_wire_voice_command_sender_top.sv
// Top level of the one-wire voice command sender: CSRs, handshake and result register.
// Latency: a result is valid on the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle unless a held result stalls; the single
// result register is refilled in the cycle it drains, so req_ready follows rsp_ready.
// Reset: synchronous; clears the sequencer to idle with the line high, empties the
// result register and restores all CSRs to their default values.
`timescale 1ns / 1ps
`default_nettype none
module one_wire_voice_command_sender_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [owvcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [owvcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [owvcs_pkg::OP_W-1:0]        req_operation,
   input  wire logic [owvcs_pkg::BYTE_W-1:0]      req_cmd_byte,
   input  wire logic [owvcs_pkg::BYTE_W-1:0]      req_addr_byte,
   input  wire logic                              req_fine_tick,
   input  wire logic                              req_coarse_tick,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_line_level,
   output logic                                   rsp_busy_res
);
   import owvcs_pkg::*;

   cfg_type  cfg_ff;
   logic     rsp_valid_ff;
   rslt_type rsp_ff;
   rslt_type rslt;
   logic     step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks <= START_LOW_RST;
         cfg_ff.one_high_ticks  <= ONE_HIGH_RST;
         cfg_ff.zero_high_ticks <= ZERO_HIGH_RST;
         cfg_ff.bit_end_ticks   <= BIT_END_RST;
         cfg_ff.play_opcode     <= PLAY_OP_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_START_LOW: cfg_ff.start_low_ticks <= csr_wdata;
            CSR_ONE_HIGH:  cfg_ff.one_high_ticks  <= csr_wdata[FINE_W-1:0];
            CSR_ZERO_HIGH: cfg_ff.zero_high_ticks <= csr_wdata[FINE_W-1:0];
            CSR_BIT_END:   cfg_ff.bit_end_ticks   <= csr_wdata[FINE_W-1:0];
            CSR_PLAY_OP:   cfg_ff.play_opcode     <= csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   owvcs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cfg         (cfg_ff),
      .operation   (req_operation),
      .cmd_byte    (req_cmd_byte),
      .addr_byte   (req_addr_byte),
      .fine_tick   (req_fine_tick),
      .coarse_tick (req_coarse_tick),
      .rslt        (rslt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rslt;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = rsp_ff.line_level;
   assign rsp_busy_res   = rsp_ff.busy;

endmodule
`default_nettype wire

### hdl/owvcs_core.sv
// Transfer sequencer: phase, tick counters, bit index and byte registers.
`timescale 1ns / 1ps
`default_nettype none
module owvcs_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire owvcs_pkg::cfg_type            cfg,
   input  wire logic [owvcs_pkg::OP_W-1:0]    operation,
   input  wire logic [owvcs_pkg::BYTE_W-1:0]  cmd_byte,
   input  wire logic [owvcs_pkg::BYTE_W-1:0]  addr_byte,
   input  wire logic                          fine_tick,
   input  wire logic                          coarse_tick,
   output owvcs_pkg::rslt_type                rslt
);
   import owvcs_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [START_W-1:0] start_count_ff, start_count_in;
   logic [FINE_W-1:0]  fine_count_ff, fine_count_in;
   logic [BIT_W-1:0]   bit_index_ff, bit_index_in;
   logic [BYTE_W-1:0]  command_ff, command_in;
   logic [BYTE_W-1:0]  address_ff, address_in;
   logic               line_ff, line_in;
   logic [BYTE_W-1:0]  cur_byte;
   logic               cur_bit;
   logic [FINE_W-1:0]  high_ticks;
   logic               start_done;

   always_comb begin
      phase_in       = phase_ff;
      start_count_in = start_count_ff;
      fine_count_in  = fine_count_ff;
      bit_index_in   = bit_index_ff;
      command_in     = command_ff;
      address_in     = address_ff;
      line_in        = line_ff;

      // a new request restarts whatever is running
      if (operation == OP_CMD || operation == OP_PLAY) begin
         phase_in       = PH_START;
         start_count_in = '0;
         fine_count_in  = '0;
         bit_index_in   = '0;
         if (operation == OP_CMD) begin
            command_in = cmd_byte;
         end else begin
            command_in = cfg.play_opcode;
            address_in = addr_byte;
         end
      end

      if (coarse_tick && start_count_in != START_MAX) begin
         start_count_in = start_count_in + 1'b1;
      end
      if (fine_tick && fine_count_in != FINE_MAX) begin
         fine_count_in = fine_count_in + 1'b1;
      end

      cur_byte   = (phase_in == PH_ADDR) ? address_in : command_in;
      cur_bit    = cur_byte[bit_index_in[2:0]];
      high_ticks = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
      start_done = (start_count_in >= cfg.start_low_ticks);

      case (phase_in)
         PH_IDLE: begin
            line_in        = 1'b1;
            start_count_in = '0;
         end
         PH_START: begin
            line_in = 1'b0;
            if (start_done) begin
               start_count_in = '0;
               phase_in       = PH_CMD;
               bit_index_in   = '0;
               fine_count_in  = '0;
            end
         end
         PH_CMD, PH_ADDR: begin
            if (bit_index_in < BYTE_BITS) begin
               if (fine_count_in <= high_ticks) begin
                  line_in = 1'b1;
               end else if (fine_count_in <= cfg.bit_end_ticks) begin
                  line_in = 1'b0;
               end else begin
                  bit_index_in  = bit_index_in + 1'b1;
                  fine_count_in = '0;
               end
               if (phase_in == PH_CMD) begin
                  start_count_in = '0;
               end
            end else if (phase_in == PH_CMD && command_in == cfg.play_opcode) begin
               // gap before the address byte, line keeps its last level
               if (start_done) begin
                  start_count_in = '0;
                  phase_in       = PH_ADDR;
                  bit_index_in   = '0;
                  fine_count_in  = '0;
               end
            end else begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         start_count_ff <= '0;
         fine_count_ff  <= '0;
         bit_index_ff   <= '0;
         command_ff     <= '0;
         address_ff     <= '0;
         line_ff        <= 1'b1;
      end else if (step) begin
         phase_ff       <= phase_in;
         start_count_ff <= start_count_in;
         fine_count_ff  <= fine_count_in;
         bit_index_ff   <= bit_index_in;
         command_ff     <= command_in;
         address_ff     <= address_in;
         line_ff        <= line_in;
      end
   end

   assign rslt.line_level = line_in;
   assign rslt.busy       = (phase_in != PH_IDLE);

endmodule
`default_nettype wire

### hdl/owvcs_checker.sv
// Port-level checker for the one-wire voice command sender, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module owvcs_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [owvcs_pkg::OP_W-1:0]        req_operation,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_line_level,
   input wire logic                              rsp_busy_res
);
   import owvcs_pkg::*;

   // nothing is pending right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending right after reset");

   // the block never stalls requests while its result slot can drain
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled with a free result slot");

   // each accepted transaction yields a result; a new request always reports busy
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == OP_CMD || req_operation == OP_PLAY))
      |=> (rsp_valid && rsp_busy_res))
      else $error("request did not produce a busy result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_line_level) && $stable(rsp_busy_res)))
      else $error("stalled result changed");

endmodule

bind one_wire_voice_command_sender_top owvcs_checker u_owvcs_checker (.*);
`default_nettype wire

### tb/sv/tb_one_wire_voice_command_sender_top.sv
// Self-checking testbench for the one-wire voice command sender, with a line-level scoreboard.
`timescale 1ns / 1ps

import owvcs_pkg::*;

class line_level_scoreboard;
   logic [START_W-1:0] start_low_ticks;
   logic [FINE_W-1:0]  one_high_ticks;
   logic [FINE_W-1:0]  zero_high_ticks;
   logic [FINE_W-1:0]  bit_end_ticks;
   logic [BYTE_W-1:0]  play_opcode;

   phase_type          phase;
   logic [START_W-1:0] start_count;
   logic [FINE_W-1:0]  fine_count;
   logic [BIT_W-1:0]   bit_index;
   logic [BYTE_W-1:0]  command_byte;
   logic [BYTE_W-1:0]  address_byte;
   logic               line_q;

   rslt_type           expected_levels[$];
   int                 errors;
   int                 requests;
   int                 checked;

   function new();
      start_low_ticks = START_LOW_RST;
      one_high_ticks  = ONE_HIGH_RST;
      zero_high_ticks = ZERO_HIGH_RST;
      bit_end_ticks   = BIT_END_RST;
      play_opcode     = PLAY_OP_RST;
      phase           = PH_IDLE;
      start_count     = '0;
      fine_count      = '0;
      bit_index       = '0;
      command_byte    = '0;
      address_byte    = '0;
      line_q          = 1'b1;
      errors          = 0;
      requests        = 0;
      checked         = 0;
   endfunction

   function void write_reg(input logic [CSR_IDX_W-1:0] reg_index,
                           input logic [CSR_DATA_W-1:0] reg_data);
      case (reg_index)
         CSR_START_LOW: start_low_ticks = reg_data;
         CSR_ONE_HIGH:  one_high_ticks  = reg_data[FINE_W-1:0];
         CSR_ZERO_HIGH: zero_high_ticks = reg_data[FINE_W-1:0];
         CSR_BIT_END:   bit_end_ticks   = reg_data[FINE_W-1:0];
         CSR_PLAY_OP:   play_opcode     = reg_data[BYTE_W-1:0];
         default: ;
      endcase
   endfunction

   // start low and inter-byte gap both end on the same coarse count
   function void end_start_period();
      if (start_count >= start_low_ticks) begin
         start_count = '0;
         phase       = (phase == PH_START) ? PH_CMD : PH_ADDR;
         bit_index   = '0;
         fine_count  = '0;
      end
   endfunction

   function void shape_bit(input logic [BYTE_W-1:0] value);
      logic [FINE_W-1:0] high_limit;
      high_limit = value[bit_index[2:0]] ? one_high_ticks : zero_high_ticks;
      if (fine_count <= high_limit) begin
         line_q = 1'b1;
      end else if (fine_count <= bit_end_ticks) begin
         line_q = 1'b0;
      end else begin
         bit_index  = bit_index + 1'b1;
         fine_count = '0;
      end
   endfunction

   function void note_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] cmd,
                              input logic [BYTE_W-1:0] addr, input logic fine,
                              input logic coarse);
      rslt_type level;
      requests++;
      if (op == OP_CMD || op == OP_PLAY) begin
         phase       = PH_START;
         start_count = '0;
         fine_count  = '0;
         bit_index   = '0;
         if (op == OP_CMD) begin
            command_byte = cmd;
         end else begin
            command_byte = play_opcode;
            address_byte = addr;
         end
      end
      if (coarse && start_count != START_MAX) start_count = start_count + 1'b1;
      if (fine && fine_count != FINE_MAX) fine_count = fine_count + 1'b1;
      case (phase)
         PH_IDLE: begin
            line_q      = 1'b1;
            start_count = '0;
         end
         PH_START: begin
            line_q = 1'b0;
            end_start_period();
         end
         PH_CMD: begin
            if (bit_index < BYTE_BITS) begin
               shape_bit(command_byte);
               start_count = '0;
            end else if (command_byte == play_opcode) begin
               end_start_period();
            end else begin
               phase = PH_IDLE;
            end
         end
         default: begin
            if (bit_index < BYTE_BITS) shape_bit(address_byte);
            else phase = PH_IDLE;
         end
      endcase
      level.line_level = line_q;
      level.busy       = (phase != PH_IDLE);
      expected_levels.push_back(level);
   endfunction

   function void check_result(input logic line_level, input logic busy);
      rslt_type want;
      checked++;
      if (expected_levels.size() == 0) begin
         errors++;
         $display("%0t: result with no request waiting, expected none, actual line %0b busy %0b",
                  $time, line_level, busy);
         return;
      end
      want = expected_levels.pop_front();
      if (line_level !== want.line_level) begin
         errors++;
         $display("%0t: line_level mismatch, expected %0b actual %0b",
                  $time, want.line_level, line_level);
      end
      if (busy !== want.busy) begin
         errors++;
         $display("%0t: busy_res mismatch, expected %0b actual %0b", $time, want.busy, busy);
      end
   endfunction

   function bit is_busy();
      return phase != PH_IDLE;
   endfunction

   function int pending();
      return expected_levels.size();
   endfunction
endclass

module tb_one_wire_voice_command_sender_top;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int IDLE_PCT        = 27;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  csr_wen         = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;
   logic                  req_valid       = 1'b0;
   logic [OP_W-1:0]       req_operation   = OP_NONE;
   logic [BYTE_W-1:0]     req_cmd_byte    = '0;
   logic [BYTE_W-1:0]     req_addr_byte   = '0;
   logic                  req_fine_tick   = 1'b0;
   logic                  req_coarse_tick = 1'b0;
   logic                  rsp_ready       = 1'b0;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_line_level;
   logic                  rsp_busy_res;

   logic idling_on      = 1'b1;
   logic hold_off_armed = 1'b0;
   int   hold_offs      = 0;
   int   setups         = 0;
   int   cycle_count    = 0;

   line_level_scoreboard levels = new();

   one_wire_voice_command_sender_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_cmd_byte    (req_cmd_byte),
      .req_addr_byte   (req_addr_byte),
      .req_fine_tick   (req_fine_tick),
      .req_coarse_tick (req_coarse_tick),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_level  (rsp_line_level),
      .rsp_busy_res    (rsp_busy_res)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("one_wire_voice_command_sender_top regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) levels.check_result(rsp_line_level, rsp_busy_res);
   end

   // result side: random stalls, plus one long hold-off so the input backs up
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            hold_offs++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic offer_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] cmd,
                             input logic [BYTE_W-1:0] addr, input logic fine,
                             input logic coarse);
      while (idling_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_cmd_byte    <= cmd;
      req_addr_byte   <= addr;
      req_fine_tick   <= fine;
      req_coarse_tick <= coarse;
      do @(posedge clock); while (!req_ready);
      levels.note_request(op, cmd, addr, fine, coarse);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] reg_data);
      csr_wen   <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= reg_data;
      levels.write_reg(reg_index, reg_data);
      @(posedge clock);
   endtask

   task automatic load_timing(input logic [START_W-1:0] start_low, input logic [FINE_W-1:0] one_hi,
                              input logic [FINE_W-1:0] zero_hi, input logic [FINE_W-1:0] bit_end,
                              input logic [BYTE_W-1:0] play_op);
      csr_write(CSR_START_LOW, start_low);
      csr_write(CSR_ONE_HIGH, {8'h00, one_hi});
      csr_write(CSR_ZERO_HIGH, {8'h00, zero_hi});
      csr_write(CSR_BIT_END, {8'h00, bit_end});
      csr_write(CSR_PLAY_OP, {8'h00, play_op});
      csr_wen <= 1'b0;
      setups++;
   endtask

   // also lets the last result settle before the sequencer may be reconfigured
   task automatic wait_drained();
      do @(posedge clock); while (levels.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   // mostly complete transfers with random bytes; rare restarts and unused opcodes as noise
   task automatic send_random_items(input int count, input int fine_pct, input int coarse_pct);
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] cmd;
      logic [BYTE_W-1:0] addr;
      int                roll;
      for (int n = 0; n < count; n++) begin
         op   = OP_NONE;
         cmd  = 8'($urandom_range(255));
         addr = 8'($urandom_range(255));
         roll = $urandom_range(99);
         if (roll < 3) op = OP_UNUSED;
         else if (levels.is_busy() ? (roll < 4) : (roll < 28))
            op = $urandom_range(1) ? OP_CMD : OP_PLAY;
         if (op == OP_CMD && $urandom_range(2) == 0) cmd = levels.play_opcode;
         offer_item(op, cmd, addr, $urandom_range(99) < fine_pct,
                    $urandom_range(99) < coarse_pct);
      end
      req_valid <= 1'b0;
      wait_drained();
   endtask

   initial begin
      int leftover;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes and every opcode at the reset timing
      offer_item(OP_NONE,   8'h00, 8'h00, 1'b0, 1'b0);
      offer_item(OP_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1);
      offer_item(OP_CMD,    8'h00, 8'hFF, 1'b1, 1'b1);
      offer_item(OP_NONE,   8'hFF, 8'h00, 1'b1, 1'b1);
      offer_item(OP_NONE,   8'h00, 8'h00, 1'b0, 1'b1);
      offer_item(OP_PLAY,   8'hFF, 8'h00, 1'b0, 1'b1);
      offer_item(OP_PLAY,   8'h00, 8'hFF, 1'b1, 1'b0);
      offer_item(OP_CMD,    8'hFF, 8'h00, 1'b1, 1'b0);
      offer_item(OP_CMD,    PLAY_OP_RST, 8'hA5, 1'b1, 1'b1);
      offer_item(OP_UNUSED, 8'h55, 8'h5A, 1'b0, 1'b0);
      offer_item(OP_NONE,   8'hAA, 8'h55, 1'b1, 1'b1);
      offer_item(OP_UNUSED, 8'h00, 8'h00, 1'b1, 1'b0);
      req_valid <= 1'b0;
      wait_drained();

      load_timing(16'd2, 8'd6, 8'd2, 8'd8, PLAY_OP_RST);
      send_random_items(200, 80, 70);

      // zero start length; zero bits stay high past the bit end
      load_timing(16'd0, 8'd0, 8'd255, 8'd1, 8'h00);
      send_random_items(150, 90, 50);

      idling_on = 1'b0;
      load_timing(16'd1, 8'd255, 8'd0, 8'd3, 8'hFF);
      send_random_items(150, 85, 85);
      idling_on = 1'b1;

      load_timing(16'hFFFF, 8'd3, 8'd1, 8'd4, 8'h5A);
      send_random_items(40, 100, 100);

      // bit end at full count never ends a bit
      load_timing(16'd3, 8'd4, 8'd1, 8'd255, PLAY_OP_RST);
      send_random_items(200, 100, 80);

      load_timing(16'd1, 8'd100, 8'd50, 8'd254, 8'h3C);
      send_random_items(280, 100, 90);

      load_timing(16'd4, 8'd3, 8'd1, 8'd5, 8'($urandom_range(255)));
      hold_off_armed = 1'b1;
      send_random_items(200, 75, 65);

      leftover = levels.pending();
      $display("covered %0d request transactions, %0d checked results, %0d timing setups",
               levels.requests, levels.checked, setups);
      $display("register extremes, restarts, saturated fine count, %0d long receiver hold-off(s)",
               hold_offs);
      if (leftover != 0) $display("%0t: %0d expected results never arrived", $time, leftover);
      if (levels.errors == 0 && leftover == 0) begin
         $display("one_wire_voice_command_sender_top regression: pass");
      end else begin
         $display("one_wire_voice_command_sender_top regression: fail");
      end
      $finish;
   end
endmodule
